>>> src/bps_pkg.sv
// shared constants, types and helper functions of the byte pattern search block
`timescale 1ns / 1ps

package bps_pkg;

  localparam int BYTE_W          = 8;
  localparam int OFFSET_W        = 64;
  localparam int LEN_W           = 5;
  localparam int COUNT_W         = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int REG_BYTES       = 8;
  localparam int MAX_PATTERN_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXACT_CASE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_LIMIT    = 3'd5;

  localparam logic               EXACT_CASE_RST  = 1'b1;
  localparam logic [COUNT_W-1:0] MATCH_LIMIT_RST = 10'd1000;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_DELTA   = 8'h20;

  // compare result handed from the matcher to the pipeline
  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] rel;
  } match_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic case_sens);
    logic [BYTE_W-1:0] res;
    res = b;
    if (!case_sens && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
      res = b + CASE_DELTA;
    end
    return res;
  endfunction

  // pattern bytes beyond the two registers read as zero
  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [CFG_DATA_W-1:0] lo,
                                                     input logic [CFG_DATA_W-1:0] hi,
                                                     input int unsigned k);
    logic [BYTE_W-1:0] res;
    res = '0;
    if (k < REG_BYTES) begin
      res = BYTE_W'(lo >> (BYTE_W * k));
    end else if (k < 2 * REG_BYTES) begin
      res = BYTE_W'(hi >> (BYTE_W * (k - REG_BYTES)));
    end
    return res;
  endfunction

endpackage

>>> src/byte_pattern_search_top.sv
// top level of the byte pattern search block: config registers, window state, pipeline
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    in_data_byte, in_last_in
// out       source     out_valid / out_stall  out_match_offset, out_match_len
// cfg       sink       cfg_wr_en              cfg_index, cfg_wdata
//
// one byte per cycle sustained while the output does not stall; a taken byte's match
// passes the input register, the compare stage and the offset add into the output register
// reset is synchronous and clears config to defaults, the window state and all valids
// a stalled output holds its stages; in_stall rises only once all three stages are full
// the byte flagged last clears the window state after its own compare

module byte_pattern_search_top #(
  parameter int MAX_PATTERN_BYTES = bps_pkg::MAX_PATTERN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bps_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                              in_last_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bps_pkg::OFFSET_W-1:0]      out_match_offset,
  output logic [bps_pkg::LEN_W-1:0]         out_match_len,
  input  logic                              cfg_wr_en,
  input  logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int HIST_D = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;

  // configuration
  logic [bps_pkg::CFG_DATA_W-1:0] pattern_low_r;
  logic [bps_pkg::CFG_DATA_W-1:0] pattern_high_r;
  logic [bps_pkg::LEN_W-1:0]      pattern_length_r;
  logic                           exact_case_r;
  logic [bps_pkg::OFFSET_W-1:0]   base_offset_r;
  logic [bps_pkg::COUNT_W-1:0]    match_limit_r;

  // window state
  logic [bps_pkg::BYTE_W-1:0]     hist_r [HIST_D];
  logic [HIST_D*bps_pkg::BYTE_W-1:0] hist_flat;
  logic [bps_pkg::OFFSET_W-1:0]   pos_r;
  logic [bps_pkg::OFFSET_W-1:0]   pos_nxt;
  logic [bps_pkg::COUNT_W-1:0]    cnt_r;
  logic [bps_pkg::COUNT_W-1:0]    cnt_nxt;

  // pipeline
  logic                           a_vld_r;
  logic [bps_pkg::BYTE_W-1:0]     a_data_r;
  logic                           a_last_r;
  logic                           b_vld_r;
  logic [bps_pkg::OFFSET_W-1:0]   b_rel_r;
  logic [bps_pkg::LEN_W-1:0]      b_len_r;
  logic                           out_vld_r;
  logic [bps_pkg::OFFSET_W-1:0]   out_off_r;
  logic [bps_pkg::LEN_W-1:0]      out_len_r;

  logic                           c_free;
  logic                           b_free;
  logic                           a_fire;
  logic                           in_fire;
  bps_pkg::match_t                cmp;

  assign c_free  = !out_vld_r || !out_stall;
  assign b_free  = !b_vld_r || c_free;
  assign a_fire  = a_vld_r && b_free;
  assign in_stall = a_vld_r && !b_free;
  assign in_fire = in_valid && !in_stall;

  assign out_valid        = out_vld_r;
  assign out_match_offset = out_off_r;
  assign out_match_len    = out_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= '0;
      exact_case_r     <= bps_pkg::EXACT_CASE_RST;
      base_offset_r    <= '0;
      match_limit_r    <= bps_pkg::MATCH_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bps_pkg::REG_PATTERN_LOW:    pattern_low_r    <= cfg_wdata;
        bps_pkg::REG_PATTERN_HIGH:   pattern_high_r   <= cfg_wdata;
        bps_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[bps_pkg::LEN_W-1:0];
        bps_pkg::REG_EXACT_CASE:     exact_case_r     <= cfg_wdata[0];
        bps_pkg::REG_BASE_OFFSET:    base_offset_r    <= cfg_wdata;
        bps_pkg::REG_MATCH_LIMIT:    match_limit_r    <= cfg_wdata[bps_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < HIST_D; i++) begin
      hist_flat[i*bps_pkg::BYTE_W +: bps_pkg::BYTE_W] = hist_r[i];
    end
  end

  bps_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .HIST_D            (HIST_D)
  ) u_match (
    .cur_byte       (a_data_r),
    .hist           (hist_flat),
    .pattern_low    (pattern_low_r),
    .pattern_high   (pattern_high_r),
    .pattern_length (pattern_length_r),
    .exact_case     (exact_case_r),
    .byte_pos       (pos_r),
    .match_count    (cnt_r),
    .match_limit    (match_limit_r),
    .result         (cmp)
  );

  // position saturates at all ones
  assign pos_nxt = (&pos_r) ? pos_r : pos_r + bps_pkg::OFFSET_W'(1);
  assign cnt_nxt = cmp.hit ? cnt_r + bps_pkg::COUNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_D; i++) begin
        hist_r[i] <= '0;
      end
      pos_r <= '0;
      cnt_r <= '0;
    end else if (a_fire) begin
      if (a_last_r) begin
        for (int i = 0; i < HIST_D; i++) begin
          hist_r[i] <= '0;
        end
        pos_r <= '0;
        cnt_r <= '0;
      end else begin
        hist_r[0] <= a_data_r;
        for (int i = 1; i < HIST_D; i++) begin
          hist_r[i] <= hist_r[i-1];
        end
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!a_vld_r || b_free) begin
        a_vld_r <= in_fire;
      end
      if (b_free) begin
        b_vld_r <= a_fire && cmp.hit;
      end
      if (c_free) begin
        out_vld_r <= b_vld_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_data_r <= in_data_byte;
      a_last_r <= in_last_in;
    end
    if (b_free) begin
      b_rel_r <= cmp.rel;
      b_len_r <= pattern_length_r;
    end
    if (c_free) begin
      out_off_r <= base_offset_r + b_rel_r;
      out_len_r <= b_len_r;
    end
  end

endmodule

>>> src/bps_match.sv
// parallel window compare: checks the newest bytes against the configured pattern
`timescale 1ns / 1ps

module bps_match #(
  parameter int MAX_PATTERN_BYTES = bps_pkg::MAX_PATTERN_DEF,
  parameter int HIST_D            = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1
) (
  input  logic [bps_pkg::BYTE_W-1:0]        cur_byte,
  input  logic [HIST_D*bps_pkg::BYTE_W-1:0] hist,
  input  logic [bps_pkg::CFG_DATA_W-1:0]    pattern_low,
  input  logic [bps_pkg::CFG_DATA_W-1:0]    pattern_high,
  input  logic [bps_pkg::LEN_W-1:0]         pattern_length,
  input  logic                              exact_case,
  input  logic [bps_pkg::OFFSET_W-1:0]      byte_pos,
  input  logic [bps_pkg::COUNT_W-1:0]       match_count,
  input  logic [bps_pkg::COUNT_W-1:0]       match_limit,
  output bps_pkg::match_t                   result
);

  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int SEL_W = bps_pkg::LEN_W + 2;

  logic [bps_pkg::BYTE_W-1:0]   win [MAX_PATTERN_BYTES];
  logic                         len_ok;
  logic                         pos_ok;
  logic                         all_eq;
  logic [bps_pkg::OFFSET_W-1:0] len_m1;

  // win[0] is the incoming byte, win[j] the byte j steps older
  always_comb begin
    win[0] = cur_byte;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win[j] = hist[(j-1)*bps_pkg::BYTE_W +: bps_pkg::BYTE_W];
    end
  end

  always_comb begin
    logic [SEL_W-1:0]          idx;
    logic [bps_pkg::BYTE_W-1:0] d;
    logic [bps_pkg::BYTE_W-1:0] pb;
    all_eq = 1'b1;
    for (int p = 0; p < MAX_PATTERN_BYTES; p++) begin
      idx = SEL_W'(pattern_length) - SEL_W'(1) - SEL_W'(p);
      d   = win[idx[IDX_W-1:0]];
      pb  = bps_pkg::pattern_byte(pattern_low, pattern_high, p);
      if ((SEL_W'(p) < SEL_W'(pattern_length)) &&
          (bps_pkg::fold_byte(d, exact_case) != bps_pkg::fold_byte(pb, exact_case))) begin
        all_eq = 1'b0;
      end
    end
  end

  assign len_ok = (pattern_length != '0) &&
                  (SEL_W'(pattern_length) <= SEL_W'(MAX_PATTERN_BYTES));
  assign len_m1 = bps_pkg::OFFSET_W'(pattern_length) - bps_pkg::OFFSET_W'(1);
  // a match may not reach back past the start of the window
  assign pos_ok = (byte_pos >= len_m1);

  assign result.hit = len_ok && pos_ok && all_eq && (match_count < match_limit);
  assign result.rel = byte_pos - len_m1;

endmodule

>>> src/bps_checker.sv
// port level checks for the byte pattern search block, bound to the top level
`timescale 1ns / 1ps

module bps_checker #(
  parameter int MAX_PATTERN_BYTES = bps_pkg::MAX_PATTERN_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [bps_pkg::OFFSET_W-1:0]      out_match_offset,
  input logic [bps_pkg::LEN_W-1:0]         out_match_len
);

  localparam int LEN_CMP_W = bps_pkg::LEN_W + 2;

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_offset) &&
                               $stable(out_match_len))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // input backpressure only comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a reported match length is never zero and fits the window
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_len != '0) &&
                  (LEN_CMP_W'(out_match_len) <= LEN_CMP_W'(MAX_PATTERN_BYTES)))
    else $error("match length out of range");

endmodule

bind byte_pattern_search_top bps_checker #(
  .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
) u_bps_checker (.*);

>>> sim/byte_pattern_search_top_tb.sv
// self-checking testbench for byte_pattern_search_top: directed table, then random windows
`timescale 1ns / 1ps

module byte_pattern_search_top_tb;
  import bps_pkg::*;

  localparam int PAT_BYTES     = MAX_PATTERN_DEF;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int PHASE_ITEMS   = 60;
  localparam int DRAIN_CYCLES  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    logic [BYTE_W-1:0]     data;
    logic                  last;
    logic                  fixed_exp;
    logic                  exp_hit;
    logic [OFFSET_W-1:0]   exp_off;
    logic [LEN_W-1:0]      exp_len;
  } dir_row_t;

  typedef struct {
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    length;
  } match_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  in_last_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OFFSET_W-1:0]   out_match_offset;
  logic [LEN_W-1:0]      out_match_len;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the configuration registers
  logic [CFG_DATA_W-1:0] pat_lo = '0;
  logic [CFG_DATA_W-1:0] pat_hi = '0;
  logic [LEN_W-1:0]      pat_len = '0;
  logic                  exact_case = EXACT_CASE_RST;
  logic [OFFSET_W-1:0]   base_off = '0;
  logic [COUNT_W-1:0]    match_cap = MATCH_LIMIT_RST;

  // shadow of the window state
  logic [BYTE_W-1:0]     history [0:PAT_BYTES-2] = '{default: '0};
  logic [OFFSET_W-1:0]   scan_pos = '0;
  logic [COUNT_W-1:0]    hit_count = '0;

  dir_row_t   plan[$];
  match_rec_t pending_matches[$];
  match_rec_t want;
  int         error_count = 0;
  int         bytes_sent = 0;
  int         send_pct = 0;
  int         recv_pct = 0;

  byte_pattern_search_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match_offset (out_match_offset),
    .out_match_len    (out_match_len),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected match transaction: offset %h length %0d",
               out_match_offset, out_match_len);
        error_count++;
      end else begin
        want = pending_matches.pop_front();
        if (out_match_offset !== want.offset) begin
          $error("match_offset: expected %h, got %h", want.offset, out_match_offset);
          error_count++;
        end
        if (out_match_len !== want.length) begin
          $error("match_len: expected %0d, got %0d", want.length, out_match_len);
          error_count++;
        end
      end
    end
  end

  function automatic void add_row(input dir_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic void expect_match(input logic [OFFSET_W-1:0] off,
                                       input logic [LEN_W-1:0] len);
    match_rec_t m;
    m.offset = off;
    m.length = len;
    pending_matches.insert(pending_matches.size(), m);
  endfunction

  function automatic logic [BYTE_W-1:0] lower_if_folding(input logic [BYTE_W-1:0] b);
    if (!exact_case && b >= 8'h41 && b <= 8'h5a) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_at(input int k);
    if (k < 8) begin
      return pat_lo[8*k +: 8];
    end else if (k < 16) begin
      return pat_hi[8*(k-8) +: 8];
    end
    return '0;
  endfunction

  // expected outcome of one byte; advances the window shadow
  function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic last,
                                    output logic hit, output logic [OFFSET_W-1:0] off,
                                    output logic [LEN_W-1:0] len);
    logic [BYTE_W-1:0] d;
    int n;
    n = int'(pat_len);
    hit = 1'b0;
    off = '0;
    len = '0;
    if (n >= 1 && n <= PAT_BYTES && hit_count < match_cap &&
        scan_pos >= OFFSET_W'(n - 1)) begin
      hit = 1'b1;
      for (int p = 0; p < n; p++) begin
        d = (p == n - 1) ? b : history[n - 2 - p];
        if (lower_if_folding(d) != lower_if_folding(pattern_at(p))) hit = 1'b0;
      end
      if (hit) begin
        off = base_off + (scan_pos - OFFSET_W'(n - 1));
        len = LEN_W'(n);
        hit_count = hit_count + COUNT_W'(1);
      end
    end
    for (int i = PAT_BYTES - 2; i > 0; i--) history[i] = history[i-1];
    history[0] = b;
    if (scan_pos != '1) scan_pos = scan_pos + OFFSET_W'(1);
    if (last) begin
      history = '{default: '0};
      scan_pos = '0;
      hit_count = '0;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:    pat_lo = data;
      REG_PATTERN_HIGH:   pat_hi = data;
      REG_PATTERN_LENGTH: pat_len = data[LEN_W-1:0];
      REG_EXACT_CASE:     exact_case = data[0];
      REG_BASE_OFFSET:    base_off = data;
      REG_MATCH_LIMIT:    match_cap = data[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_in <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed(input logic [BYTE_W-1:0] b, input logic last);
    logic hit;
    logic [OFFSET_W-1:0] off;
    logic [LEN_W-1:0] len;
    send_byte(b, last);
    scan_byte(b, last, hit, off, len);
    if (hit) expect_match(off, len);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{ROW_WRITE, idx, data, '0, 1'b0, 1'b0, 1'b0, '0, '0};
    return r;
  endfunction

  function automatic dir_row_t byte_row(input logic [BYTE_W-1:0] b, input logic last,
                                        input logic fixed_exp, input logic exp_hit,
                                        input logic [OFFSET_W-1:0] off,
                                        input logic [LEN_W-1:0] len);
    dir_row_t r;
    r = '{ROW_BYTE, '0, '0, b, last, fixed_exp, exp_hit, off, len};
    return r;
  endfunction

  // letters near the fold range, its edges, and plain noise
  function automatic logic [BYTE_W-1:0] pick_pattern_char();
    logic [BYTE_W-1:0] letters [0:3];
    logic [BYTE_W-1:0] edges [0:7];
    int r;
    letters = '{8'h41, 8'h61, 8'h42, 8'h62};
    edges = '{8'h40, 8'h5a, 8'h5b, 8'h60, 8'h7a, 8'h7b, 8'h00, 8'hff};
    r = $urandom_range(9);
    if (r < 5) return letters[2'($urandom_range(3))];
    if (r < 7) return edges[3'($urandom_range(7))];
    return BYTE_W'($urandom);
  endfunction

  // upper bits beyond the register width are sometimes garbage
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(3) != 0) return v;
    return (junk << width) | v;
  endfunction

  task automatic pick_settings();
    logic [CFG_DATA_W-1:0] lo, hi, base;
    int len, k;
    k = $urandom_range(99);
    if (k < 5) len = 0;
    else if (k < 10) len = $urandom_range(17, 31);
    else if (k < 25) len = PAT_BYTES;
    else len = $urandom_range(1, 15);
    if ($urandom_range(9) == 0) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < 8; i++) begin
        lo[8*i +: 8] = pick_pattern_char();
        hi[8*i +: 8] = pick_pattern_char();
      end
    end
    k = $urandom_range(99);
    if (k < 20) base = 64'hffff_ffff_ffff_ffff - CFG_DATA_W'($urandom_range(40));
    else if (k < 40) base = CFG_DATA_W'($urandom_range(1000));
    else base = {$urandom, $urandom};
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, with_junk(CFG_DATA_W'(len), LEN_W));
    write_reg(REG_EXACT_CASE, with_junk(CFG_DATA_W'($urandom_range(1)), 1));
    write_reg(REG_BASE_OFFSET, base);
    k = $urandom_range(99);
    if (k < 50) write_reg(REG_MATCH_LIMIT, with_junk(CFG_DATA_W'(1000), COUNT_W));
    else if (k < 60) write_reg(REG_MATCH_LIMIT, with_junk(CFG_DATA_W'(1023), COUNT_W));
    else if (k < 70) write_reg(REG_MATCH_LIMIT, with_junk(CFG_DATA_W'(0), COUNT_W));
    else write_reg(REG_MATCH_LIMIT,
                   with_junk(CFG_DATA_W'($urandom_range(1, 5)), COUNT_W));
    if ($urandom_range(4) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
    end
  endtask

  // one search window, mostly pattern copies in filler; sometimes a noise burst
  task automatic send_window();
    logic [BYTE_W-1:0] seq[$];
    logic [BYTE_W-1:0] b;
    int wlen, n;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) feed(BYTE_W'($urandom), 1'($urandom_range(1)));
      return;
    end
    wlen = $urandom_range(1, 40);
    while (seq.size() < wlen) begin
      if ($urandom_range(99) < 35 && pat_len != 0) begin
        n = (int'(pat_len) > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
        for (int k = 0; k < n; k++) begin
          b = pattern_at(k);
          // flipped case: a hit when folding, a near miss when exact
          if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7a && $urandom_range(3) == 0) begin
            b = b ^ 8'h20;
          end
          seq.insert(seq.size(), b);
        end
        if ($urandom_range(9) == 0) void'(seq.pop_back());
      end else begin
        seq.insert(seq.size(), pick_pattern_char());
      end
    end
    foreach (seq[i]) feed(seq[i], i == seq.size() - 1);
  endtask

  initial begin
    logic hit;
    logic [OFFSET_W-1:0] off;
    logic [LEN_W-1:0] len;
    int phase_start;
    bit paused;

    // empty pattern right after reset
    add_row(byte_row(8'h00, 1'b0, 1'b1, 1'b0, '0, '0));
    // "abc", partial window and a match that would straddle two windows
    add_row(reg_row(REG_PATTERN_LOW, 64'h0063_6261));
    add_row(reg_row(REG_PATTERN_LENGTH, 64'd3));
    add_row(reg_row(REG_BASE_OFFSET, 64'h1000));
    add_row(byte_row(8'h61, 1'b0, 1'b1, 1'b0, '0, '0));
    add_row(byte_row(8'h62, 1'b1, 1'b1, 1'b0, '0, '0));
    add_row(byte_row(8'h63, 1'b0, 1'b1, 1'b0, '0, '0));
    add_row(byte_row(8'h61, 1'b0, 1'b0, 1'b0, '0, '0));
    add_row(byte_row(8'h62, 1'b0, 1'b0, 1'b0, '0, '0));
    add_row(byte_row(8'h63, 1'b1, 1'b1, 1'b1, 64'h1001, 5'd3));
    // case folding on both sides
    add_row(reg_row(REG_EXACT_CASE, 64'd0));
    add_row(reg_row(REG_PATTERN_LOW, 64'h6241));
    add_row(reg_row(REG_PATTERN_LENGTH, 64'd2));
    add_row(byte_row(8'h61, 1'b0, 1'b0, 1'b0, '0, '0));
    add_row(byte_row(8'h42, 1'b1, 1'b1, 1'b1, 64'h1000, 5'd2));
    // limit zero, then limit reached after one match
    add_row(reg_row(REG_PATTERN_LENGTH, 64'd1));
    add_row(reg_row(REG_PATTERN_LOW, 64'h61));
    add_row(reg_row(REG_MATCH_LIMIT, 64'd0));
    add_row(byte_row(8'h41, 1'b1, 1'b1, 1'b0, '0, '0));
    add_row(reg_row(REG_MATCH_LIMIT, 64'd1));
    add_row(byte_row(8'h41, 1'b0, 1'b1, 1'b1, 64'h1000, 5'd1));
    add_row(byte_row(8'h61, 1'b1, 1'b1, 1'b0, '0, '0));
    // writes past the register list, then an overlong pattern
    add_row(reg_row(REG_SPARE_LO, '1));
    add_row(reg_row(REG_SPARE_HI, 64'h5a5a_5a5a_5a5a_5a5a));
    add_row(reg_row(REG_PATTERN_LENGTH, 64'd31));
    add_row(byte_row(8'h61, 1'b1, 1'b1, 1'b0, '0, '0));
    // full-length pattern of 0xff at the top of the offset range, wrapping to zero
    add_row(reg_row(REG_PATTERN_LENGTH, 64'd16));
    add_row(reg_row(REG_PATTERN_LOW, '1));
    add_row(reg_row(REG_PATTERN_HIGH, '1));
    add_row(reg_row(REG_EXACT_CASE, 64'd1));
    add_row(reg_row(REG_BASE_OFFSET, '1));
    add_row(reg_row(REG_MATCH_LIMIT, 64'h3ff));
    repeat (PAT_BYTES - 1) add_row(byte_row(8'hff, 1'b0, 1'b0, 1'b0, '0, '0));
    add_row(byte_row(8'hff, 1'b0, 1'b1, 1'b1, '1, 5'd16));
    add_row(byte_row(8'hff, 1'b1, 1'b1, 1'b1, '0, 5'd16));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_byte(plan[i].data, plan[i].last);
        scan_byte(plan[i].data, plan[i].last, hit, off, len);
        if (plan[i].fixed_exp) begin
          if (plan[i].exp_hit) expect_match(plan[i].exp_off, plan[i].exp_len);
        end else if (hit) begin
          expect_match(off, len);
        end
      end
    end

    bytes_sent = 0;
    for (int ph = 0; bytes_sent < RANDOM_ITEMS; ph++) begin
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 67; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 67; end
        default: begin send_pct = 15; recv_pct = 15; end
      endcase
      wait_idle();
      pick_settings();
      phase_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        send_window();
        // hold the sender until the output side has emptied
        if (ph % 4 == 1 && !paused) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("byte_pattern_search_top regression: pass");
    end else begin
      $display("byte_pattern_search_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("byte_pattern_search_top regression: fail");
    $finish;
  end

endmodule

>>> byte_pattern_search_top.f
src/bps_pkg.sv
src/bps_match.sv
src/byte_pattern_search_top.sv
src/bps_checker.sv
sim/byte_pattern_search_top_tb.sv
